>>> rtl/qau_pkg.sv
// Shared definitions for the quaternion arithmetic unit: the operation codes
// and the term tables of the Hamilton product.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

   // Operation code carried by every request transaction.
   typedef logic [2:0] kind_type;

   localparam kind_type KIND_ADD      = 3'd0;
   localparam kind_type KIND_SUBTRACT = 3'd1;
   localparam kind_type KIND_MULTIPLY = 3'd2;
   localparam kind_type KIND_CONJ     = 3'd3;
   localparam kind_type KIND_SCALE    = 3'd4;
   localparam kind_type KIND_ROTATE   = 3'd5;

   // Component index (0 = w, 1 = x, 2 = y, 3 = z).
   typedef logic [1:0] comp_idx_type;

   // Hamilton product p*q: result component c is the sum over k of
   // (+/-) p[QP_IDX[c][k]] * q[QQ_IDX[c][k]], negated where QNEG is set.
   // The first term of every component is positive, which the scale
   // operation relies on.
   localparam comp_idx_type QP_IDX [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd2, 2'd3}
   };

   localparam comp_idx_type QQ_IDX [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   localparam logic QNEG [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

endpackage

`default_nettype wire

>>> rtl/quaternion_arith_unit.sv
// Quaternion arithmetic unit: add, subtract, Hamilton product, conjugate,
// scale and rotation on signed fixed-point quaternions. Depends on qau_pkg.
//
// The unit accepts one request transaction per clock while req_stall is
// low and returns one response transaction for each, in order. The seven
// register stages are: input capture, first product, first sum, rounding
// of the intermediate product, second product (by the conjugate of a),
// second sum, and final rounding with result selection into the output
// register. Each stage holds its transaction only while the stage ahead is
// full and stalled, so bubbles close up and the input keeps flowing while
// a finished response waits, until every stage is full. Products are
// summed exactly and rounded once to nearest (ties toward plus infinity);
// every component saturates, and rsp_clipped reports saturation of any
// component, including the intermediate product of a rotation. Undefined
// operation codes return zero.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arith_unit #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire qau_pkg::kind_type                 req_kind,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_a_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_b_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_scale_factor,
   // Response channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic signed [COMPONENT_WIDTH-1:0] rsp_r_w,
   output      logic signed [COMPONENT_WIDTH-1:0] rsp_r_x,
   output      logic signed [COMPONENT_WIDTH-1:0] rsp_r_y,
   output      logic signed [COMPONENT_WIDTH-1:0] rsp_r_z,
   output      logic                              rsp_clipped
);

   import qau_pkg::*;

   localparam int CW = COMPONENT_WIDTH;
   localparam int FB = FRACTION_BITS;
   // Product width: covers CW x (CW+1) signed products.
   localparam int PW = 2 * CW + 1;
   // Sum width: four signed products with headroom for negation and rounding.
   localparam int SW = 2 * CW + 4;
   localparam int NSTAGE = 7;

   localparam logic signed [SW-1:0] HALF_LSB =
      {{(SW-1){1'b0}}, 1'b1} << (FB - 1);
   localparam logic signed [SW-1:0] SUM_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COMP_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};

   // Round a full-precision sum to the component format and saturate.
   // Returns {clip, value}.
   function automatic logic [CW:0] round_sat(input logic signed [SW-1:0] sum);
      logic signed [SW-1:0] shifted;
      shifted = (sum + HALF_LSB) >>> FB;
      if (shifted > SUM_MAX) begin
         round_sat = {1'b1, COMP_MAX};
      end else if (shifted < SUM_MIN) begin
         round_sat = {1'b1, COMP_MIN};
      end else begin
         round_sat = {1'b0, shifted[CW-1:0]};
      end
   endfunction

   // Saturate a value one bit wider than a component. Returns {clip, value}.
   function automatic logic [CW:0] sat_narrow(input logic signed [CW:0] val);
      if (val[CW] != val[CW-1]) begin
         sat_narrow = {1'b1, (val[CW] ? COMP_MIN : COMP_MAX)};
      end else begin
         sat_narrow = {1'b0, val[CW-1:0]};
      end
   endfunction

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   logic [NSTAGE:1] valid_ff;
   logic [NSTAGE:1] valid_in;
   logic [NSTAGE:1] adv;

   // A stage loads when it is empty or when the stage ahead loads too.
   always_comb begin
      adv[NSTAGE] = !valid_ff[NSTAGE] || !rsp_stall;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = req_valid;
      for (int k = 2; k <= NSTAGE; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NSTAGE; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !adv[1];
   assign rsp_valid = valid_ff[NSTAGE];

   // ------------------------------------------------------------------
   // Stage 1: capture the request transaction
   // ------------------------------------------------------------------
   kind_type                s1_kind_ff;
   logic signed [CW-1:0]    s1_a_ff [4];
   logic signed [CW-1:0]    s1_b_ff [4];
   logic signed [CW-1:0]    s1_sf_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_kind_ff <= req_kind;
         s1_a_ff[0] <= req_a_w;
         s1_a_ff[1] <= req_a_x;
         s1_a_ff[2] <= req_a_y;
         s1_a_ff[3] <= req_a_z;
         s1_b_ff[0] <= req_b_w;
         s1_b_ff[1] <= req_b_x;
         s1_b_ff[2] <= req_b_y;
         s1_b_ff[3] <= req_b_z;
         s1_sf_ff   <= req_scale_factor;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: first products (a*b, or a times the scale factor) and the
   // element-wise operations
   // ------------------------------------------------------------------
   logic signed [PW-1:0]    s2_prod_in [4][4];
   logic signed [CW-1:0]    s2_simple_in [4];
   logic                    s2_sclip_in;
   logic signed [PW-1:0]    s2_prod_ff [4][4];
   logic signed [CW-1:0]    s2_simple_ff [4];
   logic                    s2_sclip_ff;
   kind_type                s2_kind_ff;
   logic signed [CW-1:0]    s2_a_ff [4];

   // The scale operation reuses the first term of each component.
   always_comb begin
      logic signed [CW-1:0]   mx;
      logic signed [CW-1:0]   my;
      logic signed [2*CW-1:0] mul;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            if (s1_kind_ff == KIND_SCALE) begin
               mx = s1_a_ff[c];
               my = (k == 0) ? s1_sf_ff : '0;
            end else begin
               mx = s1_a_ff[QP_IDX[c][k]];
               my = s1_b_ff[QQ_IDX[c][k]];
            end
            mul = (2*CW)'(mx) * (2*CW)'(my);
            s2_prod_in[c][k] = PW'(mul);
         end
      end
   end

   // Add, subtract and conjugate are finished here.
   always_comb begin
      logic signed [CW:0] wide_a;
      logic signed [CW:0] wide_b;
      logic signed [CW:0] val;
      logic [CW:0]        sat;
      s2_sclip_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         wide_a = {s1_a_ff[i][CW-1], s1_a_ff[i]};
         wide_b = {s1_b_ff[i][CW-1], s1_b_ff[i]};
         case (s1_kind_ff)
            KIND_ADD:      val = wide_a + wide_b;
            KIND_SUBTRACT: val = wide_a - wide_b;
            KIND_CONJ:     val = (i == 0) ? wide_a : -wide_a;
            default:       val = '0;
         endcase
         sat = sat_narrow(val);
         s2_simple_in[i] = sat[CW-1:0];
         s2_sclip_in = s2_sclip_in | sat[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_prod_ff   <= s2_prod_in;
         s2_simple_ff <= s2_simple_in;
         s2_sclip_ff  <= s2_sclip_in;
         s2_kind_ff   <= s1_kind_ff;
         s2_a_ff      <= s1_a_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: exact sums of the first products
   // ------------------------------------------------------------------
   logic signed [SW-1:0]    s3_sum_in [4];
   logic signed [SW-1:0]    s3_sum_ff [4];
   logic signed [CW-1:0]    s3_simple_ff [4];
   logic                    s3_sclip_ff;
   kind_type                s3_kind_ff;
   logic signed [CW-1:0]    s3_a_ff [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         s3_sum_in[c] = '0;
         for (int k = 0; k < 4; k++) begin
            if (QNEG[c][k]) begin
               s3_sum_in[c] = s3_sum_in[c] - SW'(s2_prod_ff[c][k]);
            end else begin
               s3_sum_in[c] = s3_sum_in[c] + SW'(s2_prod_ff[c][k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_sum_ff    <= s3_sum_in;
         s3_simple_ff <= s2_simple_ff;
         s3_sclip_ff  <= s2_sclip_ff;
         s3_kind_ff   <= s2_kind_ff;
         s3_a_ff      <= s2_a_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: round the first product and pick the early result for every
   // operation but rotation
   // ------------------------------------------------------------------
   logic signed [CW-1:0]    s4_t_in [4];
   logic                    s4_tclip_in;
   logic signed [CW-1:0]    s4_early_in [4];
   logic                    s4_eclip_in;
   logic signed [CW-1:0]    s4_t_ff [4];
   logic                    s4_tclip_ff;
   logic signed [CW-1:0]    s4_early_ff [4];
   logic                    s4_eclip_ff;
   kind_type                s4_kind_ff;
   logic signed [CW-1:0]    s4_a_ff [4];

   always_comb begin
      logic [CW:0] rs;
      s4_tclip_in = 1'b0;
      for (int c = 0; c < 4; c++) begin
         rs = round_sat(s3_sum_ff[c]);
         s4_t_in[c] = rs[CW-1:0];
         s4_tclip_in = s4_tclip_in | rs[CW];
      end
      case (s3_kind_ff)
         KIND_ADD, KIND_SUBTRACT, KIND_CONJ: begin
            s4_early_in = s3_simple_ff;
            s4_eclip_in = s3_sclip_ff;
         end
         KIND_MULTIPLY, KIND_SCALE: begin
            s4_early_in = s4_t_in;
            s4_eclip_in = s4_tclip_in;
         end
         default: begin
            for (int c = 0; c < 4; c++) begin
               s4_early_in[c] = '0;
            end
            s4_eclip_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_t_ff     <= s4_t_in;
         s4_tclip_ff <= s4_tclip_in;
         s4_early_ff <= s4_early_in;
         s4_eclip_ff <= s4_eclip_in;
         s4_kind_ff  <= s3_kind_ff;
         s4_a_ff     <= s3_a_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: second products t*conj(a), conjugate signs folded in exactly
   // ------------------------------------------------------------------
   logic signed [PW-1:0]    s5_prod_in [4][4];
   logic signed [PW-1:0]    s5_prod_ff [4][4];
   logic                    s5_tclip_ff;
   logic signed [CW-1:0]    s5_early_ff [4];
   logic                    s5_eclip_ff;
   kind_type                s5_kind_ff;

   always_comb begin
      logic signed [CW:0] conj_a [4];
      conj_a[0] = {s4_a_ff[0][CW-1], s4_a_ff[0]};
      for (int i = 1; i < 4; i++) begin
         conj_a[i] = -{s4_a_ff[i][CW-1], s4_a_ff[i]};
      end
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            s5_prod_in[c][k] = PW'(s4_t_ff[QP_IDX[c][k]]) * PW'(conj_a[QQ_IDX[c][k]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_prod_ff  <= s5_prod_in;
         s5_tclip_ff <= s4_tclip_ff;
         s5_early_ff <= s4_early_ff;
         s5_eclip_ff <= s4_eclip_ff;
         s5_kind_ff  <= s4_kind_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: exact sums of the second products
   // ------------------------------------------------------------------
   logic signed [SW-1:0]    s6_sum_in [4];
   logic signed [SW-1:0]    s6_sum_ff [4];
   logic                    s6_tclip_ff;
   logic signed [CW-1:0]    s6_early_ff [4];
   logic                    s6_eclip_ff;
   kind_type                s6_kind_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         s6_sum_in[c] = '0;
         for (int k = 0; k < 4; k++) begin
            if (QNEG[c][k]) begin
               s6_sum_in[c] = s6_sum_in[c] - SW'(s5_prod_ff[c][k]);
            end else begin
               s6_sum_in[c] = s6_sum_in[c] + SW'(s5_prod_ff[c][k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_sum_ff   <= s6_sum_in;
         s6_tclip_ff <= s5_tclip_ff;
         s6_early_ff <= s5_early_ff;
         s6_eclip_ff <= s5_eclip_ff;
         s6_kind_ff  <= s5_kind_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: round the rotation and select the response transaction
   // ------------------------------------------------------------------
   logic signed [CW-1:0]    s7_r_in [4];
   logic                    s7_clip_in;
   logic signed [CW-1:0]    s7_r_ff [4];
   logic                    s7_clip_ff;

   always_comb begin
      logic [CW:0] rs;
      logic        rot_clip;
      rot_clip = s6_tclip_ff;
      for (int c = 0; c < 4; c++) begin
         rs = round_sat(s6_sum_ff[c]);
         rot_clip = rot_clip | rs[CW];
         s7_r_in[c] = (s6_kind_ff == KIND_ROTATE) ? rs[CW-1:0] : s6_early_ff[c];
      end
      s7_clip_in = (s6_kind_ff == KIND_ROTATE) ? rot_clip : s6_eclip_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_r_ff    <= s7_r_in;
         s7_clip_ff <= s7_clip_in;
      end
   end

   assign rsp_r_w     = s7_r_ff[0];
   assign rsp_r_x     = s7_r_ff[1];
   assign rsp_r_y     = s7_r_ff[2];
   assign rsp_r_z     = s7_r_ff[3];
   assign rsp_clipped = s7_clip_ff;

endmodule

`default_nettype wire

>>> tb/quaternion_arith_unit_test.sv
// Self-checking testbench for quaternion_arith_unit: bursty request driver,
// stalling response side, and an in-order scoreboard fed by a local predictor.
// Depends on qau_pkg and the quaternion_arith_unit RTL.
`timescale 1ns / 1ps

module quaternion_arith_unit_test;
   import qau_pkg::*;

   localparam int CW = 16;
   localparam int FB = 12;
   localparam int RANDOM_OPS = 1750;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;

   // Operation codes that the unit does not define.
   localparam kind_type KIND_UNDEF_LO = 3'd6;
   localparam kind_type KIND_UNDEF_HI = 3'd7;

   localparam logic [CW-1:0] COMP_MAX       = 16'h7fff;
   localparam logic [CW-1:0] COMP_MIN       = 16'h8000;
   localparam logic [CW-1:0] COMP_ZERO      = 16'h0000;
   localparam logic [CW-1:0] COMP_ONE       = 16'h1000;
   localparam logic [CW-1:0] COMP_NEG_ONE   = 16'hf000;
   localparam logic [CW-1:0] COMP_HALF      = 16'h0800;
   localparam logic [CW-1:0] COMP_NEG_LSB   = 16'hffff;
   localparam logic [CW-1:0] COMP_SQRT_HALF = 16'h0b50;

   localparam longint SAT_HI   = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint SAT_LO   = -SAT_HI - 1;
   localparam longint HALF_LSB = longint'(1) <<< (FB - 1);

   typedef struct packed {
      kind_type             kind;
      logic [3:0][CW-1:0]   a;
      logic [3:0][CW-1:0]   b;
      logic [CW-1:0]        scale;
   } quat_req_type;

   typedef struct packed {
      logic [3:0][CW-1:0]   comp;
      logic                 clipped;
   } quat_rsp_type;

   typedef logic [3:0][63:0] wide_quat_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   kind_type             req_kind;
   logic signed [CW-1:0] req_a_w, req_a_x, req_a_y, req_a_z;
   logic signed [CW-1:0] req_b_w, req_b_x, req_b_y, req_b_z;
   logic signed [CW-1:0] req_scale_factor;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [CW-1:0] rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z;
   logic                 rsp_clipped;

   quat_req_type pending_ops[$];
   quat_rsp_type expected_quats[$];
   int           error_count = 0;
   logic         req_fire = 1'b0;

   quaternion_arith_unit #(
      .COMPONENT_WIDTH(CW),
      .FRACTION_BITS  (FB)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_a_w         (req_a_w),
      .req_a_x         (req_a_x),
      .req_a_y         (req_a_y),
      .req_a_z         (req_a_z),
      .req_b_w         (req_b_w),
      .req_b_x         (req_b_x),
      .req_b_y         (req_b_y),
      .req_b_z         (req_b_z),
      .req_scale_factor(req_scale_factor),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_r_w         (rsp_r_w),
      .rsp_r_x         (rsp_r_x),
      .rsp_r_y         (rsp_r_y),
      .rsp_r_z         (rsp_r_z),
      .rsp_clipped     (rsp_clipped)
   );

   // Free-running clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Saturate an exact value to the component range.
   function automatic logic [CW-1:0] sat_comp(input longint v, inout logic clip);
      if (v > SAT_HI) begin
         clip = 1'b1;
         return COMP_MAX;
      end
      if (v < SAT_LO) begin
         clip = 1'b1;
         return COMP_MIN;
      end
      return v[CW-1:0];
   endfunction

   // Round an exact product sum to nearest, ties upward, then saturate.
   function automatic logic [CW-1:0] round_comp(input longint s, inout logic clip);
      return sat_comp((s + HALF_LSB) >>> FB, clip);
   endfunction

   // Exact (unrounded) component sums of the Hamilton product p*q.
   function automatic wide_quat_type hamilton_sums(input wide_quat_type p,
                                                   input wide_quat_type q);
      longint pw, px, py, pz, qw, qx, qy, qz;
      wide_quat_type s;
      pw = p[0]; px = p[1]; py = p[2]; pz = p[3];
      qw = q[0]; qx = q[1]; qy = q[2]; qz = q[3];
      s[0] = pw * qw - px * qx - py * qy - pz * qz;
      s[1] = pw * qx + px * qw + py * qz - pz * qy;
      s[2] = pw * qy - px * qz + py * qw + pz * qx;
      s[3] = pw * qz + px * qy - py * qx + pz * qw;
      return s;
   endfunction

   // Expected response for one request transaction.
   function automatic quat_rsp_type predict_quat(input quat_req_type q);
      wide_quat_type a, b, t, ca, s;
      quat_rsp_type  r;
      logic          clip;
      longint        v, sf;
      clip = 1'b0;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         v = $signed(q.a[i]);
         a[i] = v;
         v = $signed(q.b[i]);
         b[i] = v;
      end
      sf = $signed(q.scale);
      case (q.kind)
         KIND_ADD: begin
            for (int i = 0; i < 4; i++) r.comp[i] = sat_comp(a[i] + b[i], clip);
         end
         KIND_SUBTRACT: begin
            for (int i = 0; i < 4; i++) r.comp[i] = sat_comp(a[i] - b[i], clip);
         end
         KIND_MULTIPLY: begin
            s = hamilton_sums(a, b);
            for (int i = 0; i < 4; i++) r.comp[i] = round_comp(s[i], clip);
         end
         KIND_CONJ: begin
            r.comp[0] = q.a[0];
            for (int i = 1; i < 4; i++) r.comp[i] = sat_comp(-a[i], clip);
         end
         KIND_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               v = a[i];
               r.comp[i] = round_comp(v * sf, clip);
            end
         end
         KIND_ROTATE: begin
            // The intermediate product is rounded and saturated; the conjugate is exact.
            s = hamilton_sums(a, b);
            for (int i = 0; i < 4; i++) begin
               v = $signed(round_comp(s[i], clip));
               t[i] = v;
            end
            ca[0] = a[0];
            for (int i = 1; i < 4; i++) ca[i] = -a[i];
            s = hamilton_sums(t, ca);
            for (int i = 0; i < 4; i++) r.comp[i] = round_comp(s[i], clip);
         end
         default: begin
         end
      endcase
      r.clipped = clip;
      return r;
   endfunction

   // Component values weighted toward extremes and unit-sized magnitudes.
   function automatic logic [CW-1:0] rand_comp();
      logic [CW-1:0] v;
      case ($urandom_range(0, 9))
         0: v = COMP_MIN;
         1: v = COMP_MAX;
         2: v = COMP_ZERO;
         3, 4, 5: v = CW'($urandom());
         default: v = CW'(int'($urandom_range(0, 16384)) - 8192);
      endcase
      return v;
   endfunction

   task automatic add_op(input kind_type k,
                         input logic [CW-1:0] aw, ax, ay, az,
                         input logic [CW-1:0] bw, bx, by, bz,
                         input logic [CW-1:0] sf);
      quat_req_type q;
      q.kind = k;
      q.a = {az, ay, ax, aw};
      q.b = {bz, by, bx, bw};
      q.scale = sf;
      pending_ops.push_back(q);
   endtask

   task automatic add_random_op();
      quat_req_type q;
      if ($urandom_range(0, 31) == 0) begin
         q.kind = $urandom_range(0, 1) ? KIND_UNDEF_LO : KIND_UNDEF_HI;
      end else begin
         q.kind = kind_type'($urandom_range(KIND_ADD, KIND_ROTATE));
      end
      for (int i = 0; i < 4; i++) begin
         q.a[i] = rand_comp();
         q.b[i] = rand_comp();
      end
      q.scale = rand_comp();
      pending_ops.push_back(q);
   endtask

   task automatic report_mismatch(input string why, input quat_rsp_type want,
                                  input quat_rsp_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch (%s): expected w=%0d x=%0d y=%0d z=%0d clipped=%0b",
                  why, $signed(want.comp[0]), $signed(want.comp[1]),
                  $signed(want.comp[2]), $signed(want.comp[3]), want.clipped);
         $display("   got w=%0d x=%0d y=%0d z=%0d clipped=%0b",
                  $signed(got.comp[0]), $signed(got.comp[1]),
                  $signed(got.comp[2]), $signed(got.comp[3]), got.clipped);
      end
   endtask

   // Scoreboard: check each response transaction, then record the request
   // transaction accepted at this edge.
   always @(posedge clock) begin
      quat_rsp_type got, want;
      quat_req_type seen;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.comp = {rsp_r_z, rsp_r_y, rsp_r_x, rsp_r_w};
            got.clipped = rsp_clipped;
            if (expected_quats.size() == 0) begin
               report_mismatch("no transaction outstanding", '0, got);
            end else begin
               want = expected_quats.pop_front();
               if (got.comp[0] !== want.comp[0] || got.comp[1] !== want.comp[1] ||
                   got.comp[2] !== want.comp[2] || got.comp[3] !== want.comp[3] ||
                   got.clipped !== want.clipped) begin
                  report_mismatch("wrong field", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            seen.kind = req_kind;
            seen.a = {req_a_z, req_a_y, req_a_x, req_a_w};
            seen.b = {req_b_z, req_b_y, req_b_x, req_b_w};
            seen.scale = req_scale_factor;
            expected_quats.push_back(predict_quat(seen));
         end
         req_fire <= req_valid && !req_stall;
      end
   end

   // Request driver: bursts of random length separated by random gaps. A
   // presented transaction is held until it has been accepted.
   int           burst_left = 0;
   int           gap_left = 0;
   quat_req_type drv_item;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            drv_item = pending_ops.pop_front();
            req_kind         <= drv_item.kind;
            req_a_w          <= drv_item.a[0];
            req_a_x          <= drv_item.a[1];
            req_a_y          <= drv_item.a[2];
            req_a_z          <= drv_item.a[3];
            req_b_w          <= drv_item.b[0];
            req_b_x          <= drv_item.b[1];
            req_b_y          <= drv_item.b[2];
            req_b_z          <= drv_item.b[3];
            req_scale_factor <= drv_item.scale;
            req_valid        <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall pattern: modes of random length, plus two long hold-offs
   // that fill the pipeline and push back on the request side.
   int stall_cycle = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;

   always @(negedge clock) begin
      stall_cycle++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_cycle == 600 || stall_cycle == 2400) begin
         hold_left = 199;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= stall_cycle[2];
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Hard limit on run length.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("quaternion_arith_unit_test: errors");
      $finish;
   end

   // Stimulus, reset and end of run.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_kind = KIND_ADD;
      req_a_w = '0; req_a_x = '0; req_a_y = '0; req_a_z = '0;
      req_b_w = '0; req_b_x = '0; req_b_y = '0; req_b_z = '0;
      req_scale_factor = '0;

      // Addition and subtraction at the saturation limits, and the order of a-b.
      add_op(KIND_ADD, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
             COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_ZERO);
      add_op(KIND_ADD, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
             COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_ZERO);
      add_op(KIND_ADD, COMP_MAX, COMP_MIN, COMP_ZERO, COMP_ONE,
             COMP_MIN, COMP_MAX, COMP_ZERO, COMP_NEG_ONE, COMP_ZERO);
      add_op(KIND_SUBTRACT, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
             COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_ZERO);
      add_op(KIND_SUBTRACT, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
             COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_ZERO);
      add_op(KIND_SUBTRACT, 16'h3000, COMP_ONE, COMP_ZERO, COMP_NEG_ONE,
             COMP_ONE, 16'h2000, COMP_HALF, COMP_HALF, COMP_ZERO);
      // Products: identities, i*j, rounding ties on both signs, extremes.
      add_op(KIND_MULTIPLY, COMP_ONE, COMP_ZERO, COMP_ZERO, COMP_ZERO,
             COMP_ONE, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO);
      add_op(KIND_MULTIPLY, COMP_ZERO, COMP_ONE, COMP_ZERO, COMP_ZERO,
             COMP_ZERO, COMP_ZERO, COMP_ONE, COMP_ZERO, COMP_ZERO);
      add_op(KIND_MULTIPLY, 16'h0001, COMP_ZERO, COMP_ZERO, COMP_ZERO,
             COMP_HALF, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO);
      add_op(KIND_MULTIPLY, COMP_NEG_LSB, COMP_ZERO, COMP_ZERO, COMP_ZERO,
             COMP_HALF, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO);
      add_op(KIND_MULTIPLY, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
             COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_ZERO);
      add_op(KIND_MULTIPLY, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
             COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_ZERO);
      // Conjugate, including negation of the most negative value.
      add_op(KIND_CONJ, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
             COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO);
      add_op(KIND_CONJ, COMP_MAX, COMP_MAX, COMP_ZERO, COMP_NEG_LSB,
             COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_ZERO);
      // Scaling at the extremes of both operands.
      add_op(KIND_SCALE, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
             COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_MIN);
      add_op(KIND_SCALE, COMP_MAX, COMP_MIN, COMP_ONE, COMP_NEG_ONE,
             COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ONE);
      add_op(KIND_SCALE, COMP_MAX, 16'h1234, COMP_NEG_LSB, COMP_MIN,
             COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_ZERO);
      add_op(KIND_SCALE, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
             COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_ZERO, COMP_MAX);
      // Rotation: identity, a quarter turn about z, saturated intermediate product.
      add_op(KIND_ROTATE, COMP_ONE, COMP_ZERO, COMP_ZERO, COMP_ZERO,
             16'h1234, COMP_ONE, COMP_NEG_ONE, COMP_HALF, COMP_ZERO);
      add_op(KIND_ROTATE, COMP_SQRT_HALF, COMP_ZERO, COMP_ZERO, COMP_SQRT_HALF,
             COMP_ZERO, COMP_ONE, COMP_ZERO, COMP_ZERO, COMP_ZERO);
      add_op(KIND_ROTATE, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
             COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_ZERO);
      add_op(KIND_ROTATE, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
             COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_ZERO);
      // Undefined operation codes return zero.
      add_op(KIND_UNDEF_LO, COMP_NEG_LSB, COMP_NEG_LSB, COMP_NEG_LSB, COMP_NEG_LSB,
             COMP_NEG_LSB, COMP_NEG_LSB, COMP_NEG_LSB, COMP_NEG_LSB, COMP_NEG_LSB);
      add_op(KIND_UNDEF_HI, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN,
             COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX);

      for (int n = 0; n < RANDOM_OPS; n++) add_random_op();

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Wait for the driver to run dry, then for every response.
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_quats.size() == 0) begin
         $display("quaternion_arith_unit_test: clean");
      end else begin
         $display("quaternion_arith_unit_test: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/qau_pkg.sv
rtl/quaternion_arith_unit.sv
tb/quaternion_arith_unit_test.sv
